### rtl/fca_pkg.sv
// Shared types, widths and constants of the FAT12 cluster allocation table.
`default_nettype none
package fca_pkg;

	// Table geometry; the index width follows from the number of entries.
	localparam int TABLE_ENTRIES = 4096;
	localparam int IDX_W         = $clog2(TABLE_ENTRIES);
	localparam int END_W         = IDX_W + 1;

	// Field widths fixed by the interface.
	localparam int OP_W      = 2;
	localparam int CLUSTER_W = 12;
	localparam int SIZE_W    = 25;
	localparam int BPC_W     = 16;
	localparam int COUNT_W   = 13;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_W     = BPC_W;
	localparam int DIV_CNT_W = $clog2(SIZE_W);

	localparam logic [CLUSTER_W-1:0] END_OF_CHAIN       = 12'hFFF;
	localparam int                   FIRST_DATA_CLUSTER = 2;

	localparam logic [CLUSTER_W-1:0] LIMIT_RESET = 12'd2849;
	localparam logic [BPC_W-1:0]     BPC_RESET   = 16'd512;

	localparam logic [CFG_IDX_W-1:0] CFG_CLUSTER_LIMIT     = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_BYTES_PER_CLUSTER = 1'b1;

	typedef enum logic [OP_W-1:0] {
		OP_READ  = 2'd0,
		OP_WRITE = 2'd1,
		OP_ALLOC = 2'd2
	} op_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_READ,
		ST_COUNT,
		ST_DECIDE,
		ST_LINK,
		ST_CLOSE
	} state_t;

endpackage
`default_nettype wire

### rtl/fat12_cluster_chain_allocator_core.sv
// Top level of the FAT12 cluster allocation table: sequencer, scan datapath, divider and table.
`default_nettype none
//
// Channel   Direction  Handshake                 Payload
// command   in         start, busy               operation, cluster, entry_value, alloc_bytes
// result    out        done (one-cycle strobe)   cluster_value, status, free_count
// config    in         cfg_wen                   cfg_idx, cfg_wdata
//
// Reset sweeps the table to all free, one entry a cycle with busy high; configuration
// writes are taken meanwhile. A write or unused word is answered in the cycle after its
// accepting edge; a read is answered after the read state. An allocation is answered after
// the counting pass when it is refused or asks for nothing, and after the linking and
// closing states when it builds a chain, the 25-step divider hidden in the counting pass.
// The receiver cannot stall: each result shows on done for one cycle, and a word may enter then.
//
module fat12_cluster_chain_allocator_core (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            start,
	output logic                                 busy,
	input  wire logic [fca_pkg::OP_W-1:0]        operation,
	input  wire logic [fca_pkg::CLUSTER_W-1:0]   cluster,
	input  wire logic [fca_pkg::CLUSTER_W-1:0]   entry_value,
	input  wire logic [fca_pkg::SIZE_W-1:0]      alloc_bytes,
	output logic                                 done,
	output logic      [fca_pkg::CLUSTER_W-1:0]   cluster_value,
	output logic                                 status,
	output logic      [fca_pkg::COUNT_W-1:0]     free_count,
	input  wire logic                            cfg_wen,
	input  wire logic [fca_pkg::CFG_IDX_W-1:0]   cfg_idx,
	input  wire logic [fca_pkg::CFG_W-1:0]       cfg_wdata
);

	localparam int IDX_W   = fca_pkg::IDX_W;
	localparam int END_W   = fca_pkg::END_W;
	localparam int CL_W    = fca_pkg::CLUSTER_W;
	localparam int CNT_W   = fca_pkg::COUNT_W;
	localparam int SIZE_W  = fca_pkg::SIZE_W;

	fca_pkg::state_t st_q, st_d;

	// Configuration registers.
	logic [CL_W-1:0]             limit_q;
	logic [fca_pkg::BPC_W-1:0]   bpc_q;

	// Clearing sweep and scan pointers.
	logic [IDX_W-1:0]  clr_q;
	logic [END_W-1:0]  scan_q;
	logic [END_W-1:0]  end_q;
	logic [END_W-1:0]  end_d;
	logic              chk_vld_s1;
	logic [IDX_W-1:0]  chk_addr_s1;

	// Allocation bookkeeping.
	logic [CNT_W-1:0]   cnt_q;
	logic [SIZE_W-1:0]  need_q;
	logic               need_vld_q;
	logic [CNT_W-1:0]   taken_q;
	logic [IDX_W-1:0]   prev_q;
	logic               have_prev_q;
	logic [IDX_W-1:0]   first_q;
	logic               rd_oob_q;

	// Result register.
	logic              res_vld_q;
	logic [CL_W-1:0]   res_cluster_q;
	logic              res_status_q;
	logic [CNT_W-1:0]  res_count_q;

	// Sequencer outputs.
	logic              accept;
	logic              in_rng;
	logic              issue;
	logic              entry_free;
	logic              take;
	logic              cnt_inc;
	logic              alloc_go;
	logic              link_go;
	logic              res_load;
	logic [CL_W-1:0]   res_cluster_d;
	logic              res_status_d;
	logic [CNT_W-1:0]  res_count_d;
	logic              no_space;
	logic              need_zero;
	logic              link_full;

	// Table port.
	logic              ram_we;
	logic [IDX_W-1:0]  ram_waddr;
	logic [CL_W-1:0]   ram_wdata;
	logic [IDX_W-1:0]  ram_raddr;
	logic [CL_W-1:0]   ram_rdata;

	// Divider port.
	logic               div_done;
	logic [SIZE_W-1:0]  div_quot;

	fca_ram #(
		.DEPTH(fca_pkg::TABLE_ENTRIES),
		.WIDTH(CL_W),
		.AW   (IDX_W)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	fca_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.go      (alloc_go),
		.dividend(alloc_bytes),
		.divisor (bpc_q),
		.done    (div_done),
		.quotient(div_quot)
	);

	// The scan stops below the smaller of the limit register and the table size.
	assign end_d = ({1'b0, limit_q} > (CL_W + 1)'(fca_pkg::TABLE_ENTRIES))
		? END_W'(fca_pkg::TABLE_ENTRIES) : END_W'(limit_q);

	assign in_rng     = {1'b0, cluster} < (CL_W + 1)'(fca_pkg::TABLE_ENTRIES);
	assign accept     = start && (st_q == fca_pkg::ST_IDLE);
	assign entry_free = chk_vld_s1 && (ram_rdata == '0);
	assign no_space   = SIZE_W'(cnt_q) < need_q;
	assign need_zero  = need_q == '0;
	assign link_full  = SIZE_W'(taken_q) == need_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= fca_pkg::ST_CLEAR;
		end else begin
			st_q <= st_d;
		end
	end

	always_comb begin
		st_d          = st_q;
		ram_we        = 1'b0;
		ram_waddr     = prev_q;
		ram_wdata     = '0;
		ram_raddr     = scan_q[IDX_W-1:0];
		issue         = 1'b0;
		take          = 1'b0;
		cnt_inc       = 1'b0;
		alloc_go      = 1'b0;
		link_go       = 1'b0;
		res_load      = 1'b0;
		res_cluster_d = '0;
		res_status_d  = 1'b0;
		res_count_d   = '0;
		unique case (st_q)
			fca_pkg::ST_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_q;
				if (clr_q == IDX_W'(fca_pkg::TABLE_ENTRIES - 1)) begin
					st_d = fca_pkg::ST_IDLE;
				end
			end
			fca_pkg::ST_IDLE: begin
				ram_raddr = cluster[IDX_W-1:0];
				if (start) begin
					unique case (fca_pkg::op_t'(operation))
						fca_pkg::OP_READ: begin
							st_d = fca_pkg::ST_READ;
						end
						fca_pkg::OP_WRITE: begin
							ram_we    = in_rng;
							ram_waddr = cluster[IDX_W-1:0];
							ram_wdata = entry_value;
							res_load  = 1'b1;
						end
						fca_pkg::OP_ALLOC: begin
							alloc_go = 1'b1;
							st_d     = fca_pkg::ST_COUNT;
						end
						default: begin
							res_load = 1'b1;
						end
					endcase
				end
			end
			fca_pkg::ST_READ: begin
				res_load      = 1'b1;
				res_cluster_d = rd_oob_q ? '0 : ram_rdata;
				st_d          = fca_pkg::ST_IDLE;
			end
			fca_pkg::ST_COUNT: begin
				issue   = scan_q < end_q;
				cnt_inc = entry_free;
				if (!issue && !chk_vld_s1 && need_vld_q) begin
					st_d = fca_pkg::ST_DECIDE;
				end
			end
			fca_pkg::ST_DECIDE: begin
				res_count_d = cnt_q;
				if (no_space || need_zero) begin
					res_load     = 1'b1;
					res_status_d = no_space;
					st_d         = fca_pkg::ST_IDLE;
				end else begin
					link_go = 1'b1;
					st_d    = fca_pkg::ST_LINK;
				end
			end
			fca_pkg::ST_LINK: begin
				issue     = (scan_q < end_q) && !link_full;
				take      = entry_free && !link_full;
				ram_we    = take && have_prev_q;
				ram_wdata = CL_W'(chk_addr_s1);
				if (link_full || (!issue && !chk_vld_s1)) begin
					st_d = fca_pkg::ST_CLOSE;
				end
			end
			fca_pkg::ST_CLOSE: begin
				ram_we        = 1'b1;
				ram_wdata     = fca_pkg::END_OF_CHAIN;
				res_load      = 1'b1;
				res_cluster_d = CL_W'(first_q);
				res_count_d   = cnt_q;
				st_d          = fca_pkg::ST_IDLE;
			end
			default: begin
				st_d = fca_pkg::ST_CLEAR;
			end
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q     <= fca_pkg::LIMIT_RESET;
			bpc_q       <= fca_pkg::BPC_RESET;
			clr_q       <= '0;
			scan_q      <= '0;
			chk_vld_s1  <= 1'b0;
			cnt_q       <= '0;
			need_vld_q  <= 1'b0;
			taken_q     <= '0;
			have_prev_q <= 1'b0;
			res_vld_q   <= 1'b0;
		end else begin
			if (cfg_wen) begin
				unique case (cfg_idx)
					fca_pkg::CFG_CLUSTER_LIMIT:     limit_q <= cfg_wdata[CL_W-1:0];
					fca_pkg::CFG_BYTES_PER_CLUSTER: bpc_q   <= cfg_wdata;
				endcase
			end
			if (st_q == fca_pkg::ST_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			chk_vld_s1 <= issue;
			if (alloc_go || link_go) begin
				scan_q <= END_W'(fca_pkg::FIRST_DATA_CLUSTER);
			end else if (issue) begin
				scan_q <= scan_q + 1'b1;
			end
			if (alloc_go) begin
				cnt_q      <= '0;
				need_vld_q <= 1'b0;
			end else begin
				if (cnt_inc) begin
					cnt_q <= cnt_q + 1'b1;
				end
				if (div_done) begin
					need_vld_q <= 1'b1;
				end
			end
			if (link_go) begin
				taken_q     <= '0;
				have_prev_q <= 1'b0;
			end else if (take) begin
				taken_q     <= taken_q + 1'b1;
				have_prev_q <= 1'b1;
			end
			res_vld_q <= res_load;
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (issue) begin
			chk_addr_s1 <= scan_q[IDX_W-1:0];
		end
		if (alloc_go) begin
			end_q <= end_d;
		end
		if (accept) begin
			rd_oob_q <= !in_rng;
		end
		if (div_done) begin
			need_q <= div_quot;
		end
		if (take) begin
			prev_q <= chk_addr_s1;
			if (!have_prev_q) begin
				first_q <= chk_addr_s1;
			end
		end
		if (res_load) begin
			res_cluster_q <= res_cluster_d;
			res_status_q  <= res_status_d;
			res_count_q   <= res_count_d;
		end
	end

	assign busy          = st_q != fca_pkg::ST_IDLE;
	assign done          = res_vld_q;
	assign cluster_value = res_cluster_q;
	assign status        = res_status_q;
	assign free_count    = res_count_q;

	// A result only appears once the sequencer is back at rest.
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while the sequencer is still working");

	// A refused allocation never names a first cluster.
	a_refused_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status) |-> (cluster_value == '0))
		else $error("no-space result carries a cluster number");

	// Chain links are always written behind the entry being examined.
	a_link_behind: assert property (@(posedge clk) disable iff (!arst_n)
		((st_q == fca_pkg::ST_LINK) && ram_we) |-> (ram_waddr < chk_addr_s1))
		else $error("chain link written at or ahead of the scan");

	// The linking pass never claims more clusters than were asked for.
	a_taken_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == fca_pkg::ST_LINK) |-> (SIZE_W'(taken_q) <= need_q))
		else $error("more clusters claimed than needed");

endmodule
`default_nettype wire

### rtl/fca_ram.sv
// Generic single-write, single-read memory with registered read data.
`default_nettype none
module fca_ram #(
	parameter int DEPTH = 4096,
	parameter int WIDTH = 12,
	parameter int AW    = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

### rtl/fca_div.sv
// Restoring divider, one quotient bit a cycle, giving a quotient rounded up.
`default_nettype none
module fca_div (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         go,
	input  wire logic [fca_pkg::SIZE_W-1:0]   dividend,
	input  wire logic [fca_pkg::BPC_W-1:0]    divisor,
	output logic                              done,
	output logic      [fca_pkg::SIZE_W-1:0]   quotient
);

	logic                            run_q;
	logic                            done_q;
	logic [fca_pkg::DIV_CNT_W-1:0]   step_q;
	logic [fca_pkg::SIZE_W-1:0]      quo_q;
	logic [fca_pkg::BPC_W-1:0]       rem_q;
	logic [fca_pkg::BPC_W-1:0]       dvs_q;
	logic [fca_pkg::BPC_W:0]         rem_sh;
	logic [fca_pkg::BPC_W:0]         rem_dif;
	logic                            ge;

	assign rem_sh  = {rem_q, quo_q[fca_pkg::SIZE_W-1]};
	assign ge      = rem_sh >= {1'b0, dvs_q};
	assign rem_dif = rem_sh - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				run_q  <= 1'b1;
				step_q <= '0;
			end else if (run_q) begin
				if (step_q == fca_pkg::DIV_CNT_W'(fca_pkg::SIZE_W - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
				step_q <= step_q + 1'b1;
			end
		end
	end

	// A divisor of zero is taken as one.
	always_ff @(posedge clk) begin
		if (go) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= (divisor == '0) ? fca_pkg::BPC_W'(1) : divisor;
		end else if (run_q) begin
			quo_q <= {quo_q[fca_pkg::SIZE_W-2:0], ge};
			rem_q <= ge ? rem_dif[fca_pkg::BPC_W-1:0] : rem_sh[fca_pkg::BPC_W-1:0];
		end
	end

	assign done     = done_q;
	assign quotient = quo_q + fca_pkg::SIZE_W'(|rem_q);

endmodule
`default_nettype wire

### test/tb_fat12_cluster_chain_allocator_core.sv
`timescale 1ns / 100ps
// Self-checking testbench for the FAT12 cluster allocation table core.
module tb_fat12_cluster_chain_allocator_core;
	import fca_pkg::*;

	// The interface carries a fourth operation code that the block must ignore.
	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

	localparam int DIRECTED_N     = 23;
	localparam int PHASE_N        = 7;
	// An allocation over the full table and the clearing sweep after reset are the
	// slowest correct gaps between two handshakes; this leaves several times either.
	localparam int WATCHDOG_LIMIT = 50000;
	localparam int SETTLE_CYCLES  = 16;

	// One result word as the block presents it.
	typedef struct packed {
		logic [CLUSTER_W-1:0] value;
		logic                 no_space;
		logic [COUNT_W-1:0]   free_cnt;
	} result_t;

	// One row of the directed stimulus. Where typed is set, want holds the
	// result written into the row; otherwise the predictor decides.
	typedef struct packed {
		logic [OP_W-1:0]      op;
		logic [CLUSTER_W-1:0] idx;
		logic [CLUSTER_W-1:0] val;
		logic [SIZE_W-1:0]    size;
		logic                 typed;
		result_t              want;
	} cmd_row_t;

	// One configuration setting and the number of random words run under it.
	typedef struct packed {
		logic [CLUSTER_W-1:0] limit;
		logic [BPC_W-1:0]     bpc;
		logic [7:0]           words;
	} setting_t;

	logic                 clk         = 1'b0;
	logic                 arst_n      = 1'b0;
	logic                 start       = 1'b0;
	logic [OP_W-1:0]      operation   = '0;
	logic [CLUSTER_W-1:0] cluster     = '0;
	logic [CLUSTER_W-1:0] entry_value = '0;
	logic [SIZE_W-1:0]    alloc_bytes = '0;
	logic                 cfg_wen     = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_idx     = '0;
	logic [CFG_W-1:0]     cfg_wdata   = '0;
	logic                 busy;
	logic                 done;
	logic [CLUSTER_W-1:0] cluster_value;
	logic                 status;
	logic [COUNT_W-1:0]   free_count;

	fat12_cluster_chain_allocator_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.operation    (operation),
		.cluster      (cluster),
		.entry_value  (entry_value),
		.alloc_bytes  (alloc_bytes),
		.done         (done),
		.cluster_value(cluster_value),
		.status       (status),
		.free_count   (free_count),
		.cfg_wen      (cfg_wen),
		.cfg_idx      (cfg_idx),
		.cfg_wdata    (cfg_wdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// The testbench's own copy of the allocation table and of both registers.
	logic [CLUSTER_W-1:0] fat_model [TABLE_ENTRIES];
	logic [CLUSTER_W-1:0] model_limit;
	logic [BPC_W-1:0]     model_bpc;

	// Results still owed by the block, oldest first.
	result_t pending_results [$];

	cmd_row_t    directed_rows [DIRECTED_N];
	setting_t    settings [PHASE_N];
	int unsigned error_count     = 0;
	int unsigned results_checked = 0;
	int unsigned words_sent      = 0;
	int unsigned alloc_words     = 0;
	int unsigned refused_words   = 0;
	int unsigned burst_left      = 0;
	int unsigned quiet_cycles    = 0;

	// Applies one command word to the table copy and returns the result it
	// should give. An allocation counts the free entries of the scan window
	// first; only when there are enough does it claim the lowest free ones,
	// marking each as end of chain before linking the previous one to it.
	function automatic result_t predict_table_op(input logic [OP_W-1:0] op,
			input logic [CLUSTER_W-1:0] idx, input logic [CLUSTER_W-1:0] val,
			input logic [SIZE_W-1:0] size);
		result_t     res;
		int unsigned unit;
		int unsigned needed;
		int unsigned scan_end;
		int unsigned free_cnt;
		int unsigned taken;
		int unsigned prev;
		int unsigned c;
		res = '0;
		case (op)
			OP_READ: begin
				if (idx < TABLE_ENTRIES)
					res.value = fat_model[idx];
			end
			OP_WRITE: begin
				if (idx < TABLE_ENTRIES)
					fat_model[idx] = val;
			end
			OP_ALLOC: begin
				// A cluster size of zero is taken as one byte.
				unit     = (model_bpc == '0) ? 1 : model_bpc;
				needed   = (size + unit - 1) / unit;
				scan_end = (model_limit > TABLE_ENTRIES) ? TABLE_ENTRIES : model_limit;
				free_cnt = 0;
				for (c = FIRST_DATA_CLUSTER; c < scan_end; c++)
					if (fat_model[c] == '0)
						free_cnt++;
				res.free_cnt = free_cnt[COUNT_W-1:0];
				if (free_cnt < needed) begin
					res.no_space = 1'b1;
				end else if (needed != 0) begin
					taken = 0;
					prev  = 0;
					for (c = FIRST_DATA_CLUSTER; c < scan_end && taken < needed; c++) begin
						if (fat_model[c] != '0)
							continue;
						fat_model[c] = END_OF_CHAIN;
						if (taken == 0)
							res.value = c[CLUSTER_W-1:0];
						else
							fat_model[prev] = c[CLUSTER_W-1:0];
						prev = c;
						taken++;
					end
				end
			end
			default: ;
		endcase
		return res;
	endfunction

	function automatic cmd_row_t make_row(input logic [OP_W-1:0] op,
			input logic [CLUSTER_W-1:0] idx, input logic [CLUSTER_W-1:0] val,
			input logic [SIZE_W-1:0] size, input logic typed,
			input logic [CLUSTER_W-1:0] want_value, input logic want_no_space,
			input logic [COUNT_W-1:0] want_free);
		cmd_row_t r;
		r.op            = op;
		r.idx           = idx;
		r.val           = val;
		r.size          = size;
		r.typed         = typed;
		r.want.value    = want_value;
		r.want.no_space = want_no_space;
		r.want.free_cnt = want_free;
		return r;
	endfunction

	// Presents one command word from the falling edge and holds it until the
	// block takes it. Start is left high so that a following word in the same
	// burst goes out without a bubble.
	task automatic issue_word(input logic [OP_W-1:0] op, input logic [CLUSTER_W-1:0] idx,
			input logic [CLUSTER_W-1:0] val, input logic [SIZE_W-1:0] size,
			input logic typed, input result_t want);
		result_t predicted;
		@(negedge clk);
		start       <= 1'b1;
		operation   <= op;
		cluster     <= idx;
		entry_value <= val;
		alloc_bytes <= size;
		do
			@(posedge clk);
		while (busy);
		predicted = predict_table_op(op, idx, val, size);
		pending_results.push_back(typed ? want : predicted);
		words_sent++;
		if (op == OP_ALLOC) begin
			alloc_words++;
			if (predicted.no_space)
				refused_words++;
		end
	endtask

	// The sender works in bursts of one to twelve words, with start held low for a
	// random gap between them.
	task automatic pace_sender();
		int unsigned gap;
		if (burst_left != 0) begin
			burst_left--;
			return;
		end
		burst_left = $urandom_range(0, 11);
		gap        = $urandom_range(1, 5);
		@(negedge clk);
		start <= 1'b0;
		repeat (gap - 1) @(negedge clk);
	endtask

	// Registers are only written with the block idle and nothing outstanding.
	task automatic program_settings(input logic [CLUSTER_W-1:0] limit,
			input logic [BPC_W-1:0] bpc);
		@(negedge clk);
		start <= 1'b0;
		while (pending_results.size() != 0 || busy)
			@(posedge clk);
		@(negedge clk);
		cfg_wen   <= 1'b1;
		cfg_idx   <= CFG_CLUSTER_LIMIT;
		cfg_wdata <= CFG_W'(limit);
		@(negedge clk);
		cfg_idx   <= CFG_BYTES_PER_CLUSTER;
		cfg_wdata <= bpc;
		@(negedge clk);
		cfg_wen <= 1'b0;
		model_limit = limit;
		model_bpc   = bpc;
		burst_left  = 0;
	endtask

	// One random word. Indexes lean towards the scan window so that reads see
	// chains and writes free or block clusters that allocations will meet;
	// writes of zero are common so that the window keeps some room. Sizes are
	// mostly in proportion to the window, with a share of zero and of anything
	// the field can hold.
	task automatic random_word();
		int unsigned     roll;
		int unsigned     scan_top;
		int unsigned     unit;
		longint unsigned size_cap;
		logic [OP_W-1:0]      op;
		logic [CLUSTER_W-1:0] idx;
		logic [CLUSTER_W-1:0] val;
		logic [SIZE_W-1:0]    size;
		roll = $urandom_range(0, 99);
		if (roll < 25)
			op = OP_READ;
		else if (roll < 50)
			op = OP_WRITE;
		else if (roll < 92)
			op = OP_ALLOC;
		else
			op = OP_UNUSED;

		scan_top = (model_limit >= TABLE_ENTRIES - 2) ? TABLE_ENTRIES - 1 : model_limit + 1;
		if ($urandom_range(0, 99) < 80)
			idx = CLUSTER_W'($urandom_range(0, scan_top));
		else
			idx = CLUSTER_W'($urandom_range(0, TABLE_ENTRIES - 1));

		roll = $urandom_range(0, 99);
		if (roll < 45)
			val = '0;
		else if (roll < 60)
			val = END_OF_CHAIN;
		else
			val = CLUSTER_W'($urandom);

		unit     = (model_bpc == '0) ? 1 : model_bpc;
		size_cap = longint'(unit) * (model_limit + 2);
		if (size_cap > (1 << SIZE_W) - 1)
			size_cap = (1 << SIZE_W) - 1;
		roll = $urandom_range(0, 99);
		if (roll < 10)
			size = '0;
		else if (roll < 25)
			size = SIZE_W'($urandom);
		else
			size = SIZE_W'($urandom_range(0, int'(size_cap)));

		issue_word(op, idx, val, size, 1'b0, '0);
	endtask

	// Results are taken at the rising edge that ends their strobe cycle and
	// compared field by field with the oldest expectation.
	always @(posedge clk) begin
		result_t got;
		result_t want;
		if (arst_n && done) begin
			got = {cluster_value, status, free_count};
			if (pending_results.size() == 0) begin
				$display("%0t: result word with nothing outstanding: value %h status %b free %0d",
					$time, got.value, got.no_space, got.free_cnt);
				error_count++;
			end else begin
				want = pending_results.pop_front();
				results_checked++;
				if (got.value !== want.value) begin
					$display("%0t: cluster_value expected %h, got %h",
						$time, want.value, got.value);
					error_count++;
				end
				if (got.no_space !== want.no_space) begin
					$display("%0t: status expected %b, got %b",
						$time, want.no_space, got.no_space);
					error_count++;
				end
				if (got.free_cnt !== want.free_cnt) begin
					$display("%0t: free_count expected %0d, got %0d",
						$time, want.free_cnt, got.free_cnt);
					error_count++;
				end
			end
		end
	end

	// Watchdog: any cycle that moves a word in either direction restarts it.
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done)
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: no word moved for %0d cycles", $time, WATCHDOG_LIMIT);
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin
		int i;
		int p;
		int n;

		// The directed part starts from the cleared table with the reset
		// settings: 2847 free clusters between 2 and 2848, 512 byte clusters.
		directed_rows = '{
			make_row(OP_READ,   12'd0,     12'h000, 25'd0,        1'b1, 12'h000, 1'b0, 13'd0),
			make_row(OP_READ,   12'd4095,  12'h000, 25'd0,        1'b1, 12'h000, 1'b0, 13'd0),
			make_row(OP_WRITE,  12'd4095,  12'hFFF, 25'd0,        1'b1, 12'h000, 1'b0, 13'd0),
			make_row(OP_READ,   12'd4095,  12'h000, 25'd0,        1'b1, 12'hFFF, 1'b0, 13'd0),
			// The unused code must leave the table alone and answer with zeros.
			make_row(OP_UNUSED, 12'd7,     12'h123, 25'd100,      1'b1, 12'h000, 1'b0, 13'd0),
			// A zero size allocates nothing but still reports the count.
			make_row(OP_ALLOC,  12'd0,     12'h000, 25'd0,        1'b1, 12'h000, 1'b0, 13'd2847),
			// The largest size needs 65536 clusters, far more than are free.
			make_row(OP_ALLOC,  12'd0,     12'h000, 25'h1FFFFFF,  1'b1, 12'h000, 1'b1, 13'd2847),
			make_row(OP_ALLOC,  12'd0,     12'h000, 25'd1,        1'b1, 12'd2,   1'b0, 13'd2847),
			make_row(OP_READ,   12'd2,     12'h000, 25'd0,        1'b1, 12'hFFF, 1'b0, 13'd0),
			// One byte past a cluster rounds up to a chain of two: 3 then 4.
			make_row(OP_ALLOC,  12'd0,     12'h000, 25'd513,      1'b1, 12'd3,   1'b0, 13'd2846),
			make_row(OP_READ,   12'd3,     12'h000, 25'd0,        1'b1, 12'd4,   1'b0, 13'd0),
			make_row(OP_READ,   12'd4,     12'h000, 25'd0,        1'b1, 12'hFFF, 1'b0, 13'd0),
			// Free cluster 3 so that the next chain has a hole to fill.
			make_row(OP_WRITE,  12'd3,     12'h000, 25'd0,        1'b1, 12'h000, 1'b0, 13'd0),
			make_row(OP_ALLOC,  12'd0,     12'h000, 25'd1024,     1'b0, '0,      1'b0, '0),
			make_row(OP_WRITE,  12'hABC,   12'h555, 25'd0,        1'b1, 12'h000, 1'b0, 13'd0),
			make_row(OP_WRITE,  12'h543,   12'hAAA, 25'd0,        1'b1, 12'h000, 1'b0, 13'd0),
			make_row(OP_READ,   12'hABC,   12'h000, 25'd0,        1'b1, 12'h555, 1'b0, 13'd0),
			make_row(OP_READ,   12'h543,   12'h000, 25'd0,        1'b1, 12'hAAA, 1'b0, 13'd0),
			// A used cluster in the way of the next chain must be stepped over.
			make_row(OP_WRITE,  12'd10,    12'h7FF, 25'd0,        1'b1, 12'h000, 1'b0, 13'd0),
			make_row(OP_ALLOC,  12'd0,     12'h000, 25'd4097,     1'b0, '0,      1'b0, '0),
			make_row(OP_READ,   12'd9,     12'h000, 25'd0,        1'b0, '0,      1'b0, '0),
			// The last cluster inside the window.
			make_row(OP_WRITE,  12'd2848,  12'hFFF, 25'd0,        1'b1, 12'h000, 1'b0, 13'd0),
			make_row(OP_ALLOC,  12'd0,     12'h000, 25'd0,        1'b0, '0,      1'b0, '0)
		};

		// Settings for the random part. Most windows are small so that the two
		// passes of an allocation stay short; the largest value of both registers,
		// an empty window and a zero cluster size are among them.
		settings[0] = '{limit: 12'd40,   bpc: 16'd512,   words: 8'd22};
		settings[1] = '{limit: 12'd3,    bpc: 16'd32768, words: 8'd10};
		settings[2] = '{limit: 12'd2,    bpc: 16'd0,     words: 8'd8};
		settings[3] = '{limit: 12'd24,   bpc: 16'd1,     words: 8'd18};
		settings[4] = '{limit: 12'd4095, bpc: 16'hFFFF,  words: 8'd8};
		settings[5] = '{limit: 12'd64,   bpc: 16'd4096,  words: 8'd14};
		settings[6] = '{limit: 12'd4085, bpc: 16'd1000,  words: 8'd8};

		for (i = 0; i < TABLE_ENTRIES; i++)
			fat_model[i] = '0;
		model_limit = LIMIT_RESET;
		model_bpc   = BPC_RESET;

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// The reset values are written back explicitly; this also waits out
		// the clearing sweep, since busy stays high until it has finished.
		program_settings(LIMIT_RESET, BPC_RESET);
		for (i = 0; i < DIRECTED_N; i++) begin
			pace_sender();
			issue_word(directed_rows[i].op, directed_rows[i].idx, directed_rows[i].val,
				directed_rows[i].size, directed_rows[i].typed, directed_rows[i].want);
		end

		for (p = 0; p < PHASE_N; p++) begin
			program_settings(settings[p].limit, settings[p].bpc);
			for (n = 0; n < settings[p].words; n++) begin
				pace_sender();
				random_word();
			end
		end

		@(negedge clk);
		start <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("Ran %0d command words under %0d register settings,",
			words_sent, PHASE_N + 1);
		$display("%0d of them allocations (%0d refused for want of space).",
			alloc_words, refused_words);
		$display("Compared %0d result words and found %0d mismatching fields.",
			results_checked, error_count);
		if (error_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
